// ===== design/ilir_pkg.sv =====
package ilir_pkg;

  // Store geometry
  localparam int CAPACITY = 64;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int IW       = 6;
  localparam int DW       = 32;
  localparam int KW       = 3;
  localparam int SW       = 2;

  // Request kinds
  localparam logic [KW-1:0] KIND_APPEND = 3'd0;
  localparam logic [KW-1:0] KIND_INSERT = 3'd1;
  localparam logic [KW-1:0] KIND_REMOVE = 3'd2;
  localparam logic [KW-1:0] KIND_SWAP   = 3'd3;
  localparam logic [KW-1:0] KIND_READ   = 3'd4;

  // Status codes
  localparam logic [SW-1:0] ST_DONE  = 2'd0;
  localparam logic [SW-1:0] ST_FULL  = 2'd1;
  localparam logic [SW-1:0] ST_RANGE = 2'd2;

  // Read address select
  typedef logic [2:0] ra_sel_t;
  localparam ra_sel_t RA_IDX    = 3'd0;
  localparam ra_sel_t RA_OTH    = 3'd1;
  localparam ra_sel_t RA_IDX_P1 = 3'd2;
  localparam ra_sel_t RA_CNT_M1 = 3'd3;
  localparam ra_sel_t RA_PTR_M2 = 3'd4;
  localparam ra_sel_t RA_PTR_P2 = 3'd5;

  // Write address select
  typedef logic [1:0] wa_sel_t;
  localparam wa_sel_t WA_CNT = 2'd0;
  localparam wa_sel_t WA_PTR = 2'd1;
  localparam wa_sel_t WA_IDX = 2'd2;
  localparam wa_sel_t WA_OTH = 2'd3;

  // Write data select
  typedef logic [1:0] wd_sel_t;
  localparam wd_sel_t WD_VALUE = 2'd0;
  localparam wd_sel_t WD_RDATA = 2'd1;
  localparam wd_sel_t WD_HOLD  = 2'd2;

  // Pointer operations
  typedef logic [2:0] ptr_op_t;
  localparam ptr_op_t PTR_HOLD = 3'd0;
  localparam ptr_op_t PTR_CNT  = 3'd1;
  localparam ptr_op_t PTR_IDX  = 3'd2;
  localparam ptr_op_t PTR_DEC  = 3'd3;
  localparam ptr_op_t PTR_INC  = 3'd4;

  // Count operations
  typedef logic [1:0] cnt_op_t;
  localparam cnt_op_t CNT_HOLD = 2'd0;
  localparam cnt_op_t CNT_INC  = 2'd1;
  localparam cnt_op_t CNT_DEC  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic            capture;
    logic            rd_en;
    ra_sel_t         rd_sel;
    logic            wr_en;
    wa_sel_t         wa_sel;
    wd_sel_t         wd_sel;
    ptr_op_t         ptr_op;
    cnt_op_t         cnt_op;
    logic            hold_ld;
    logic            st_ld;
    logic [SW-1:0]   st_code;
    logic            rv_ld;
    logic            out_ld;
  } ilir_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [KW-1:0] kind;
    logic          full;
    logic          idx_le_cnt;
    logic          idx_eq_cnt;
    logic          idx_lt_cnt;
    logic          oth_lt_cnt;
    logic          idx_p1_eq_cnt;
    logic          ptr_gt_idx_p1;
    logic          ptr_p2_lt_cnt;
    logic          out_free;
  } ilir_stat_t;

endpackage

// ===== design/ilir_req_if.sv =====
interface ilir_req_if;
  logic                               valid;
  logic                               ready;
  logic [ilir_pkg::KW-1:0]            kind;
  logic [ilir_pkg::IW-1:0]            index;
  logic [ilir_pkg::IW-1:0]            other_index;
  logic signed [ilir_pkg::DW-1:0]     value;

  modport source(output valid, kind, index, other_index, value, input ready);
  modport sink(input valid, kind, index, other_index, value, output ready);
endinterface

// ===== design/ilir_rsp_if.sv =====
interface ilir_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [ilir_pkg::DW-1:0]     read_value;
  logic [ilir_pkg::SW-1:0]            status;
  logic [ilir_pkg::CW-1:0]            entry_count;

  modport source(output valid, read_value, status, entry_count, input ready);
  modport sink(input valid, read_value, status, entry_count, output ready);
endinterface

// ===== design/ilir_datapath.sv =====
module ilir_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  ilir_pkg::ilir_cmd_t             cmd,
  output ilir_pkg::ilir_stat_t            stat,
  input  logic [ilir_pkg::KW-1:0]         req_kind,
  input  logic [ilir_pkg::IW-1:0]         req_index,
  input  logic [ilir_pkg::IW-1:0]         req_other_index,
  input  logic signed [ilir_pkg::DW-1:0]  req_value,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic signed [ilir_pkg::DW-1:0]  rsp_read_value,
  output logic [ilir_pkg::SW-1:0]         rsp_status,
  output logic [ilir_pkg::CW-1:0]         rsp_entry_count
);

  // Entry store, one write and one registered read per cycle
  logic [ilir_pkg::DW-1:0] mem [ilir_pkg::CAPACITY];

  logic [ilir_pkg::KW-1:0] kind;
  logic [ilir_pkg::IW-1:0] index;
  logic [ilir_pkg::IW-1:0] other_index;
  logic [ilir_pkg::DW-1:0] value;
  logic [ilir_pkg::DW-1:0] rdata;
  logic [ilir_pkg::DW-1:0] hold;
  logic [ilir_pkg::CW-1:0] count;
  logic [ilir_pkg::CW-1:0] count_next;
  logic [ilir_pkg::CW-1:0] ptr;
  logic [ilir_pkg::CW-1:0] ptr_next;
  logic [ilir_pkg::DW-1:0] res_read;
  logic [ilir_pkg::SW-1:0] res_status;

  logic [ilir_pkg::CW-1:0] idx_ext;
  logic [ilir_pkg::CW-1:0] oth_ext;
  logic [ilir_pkg::CW-1:0] idx_p1;
  logic [ilir_pkg::CW-1:0] ra_wide;
  logic [ilir_pkg::CW-1:0] wa_wide;
  logic [ilir_pkg::AW-1:0] rd_addr;
  logic [ilir_pkg::AW-1:0] wr_addr;
  logic [ilir_pkg::DW-1:0] wr_data;

  assign idx_ext = ilir_pkg::CW'(index);
  assign oth_ext = ilir_pkg::CW'(other_index);
  assign idx_p1  = idx_ext + ilir_pkg::CW'(1);

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind        <= req_kind;
      index       <= req_index;
      other_index <= req_other_index;
      value       <= req_value;
    end
  end

  // Address and data selection
  always_comb begin
    case (cmd.rd_sel)
      ilir_pkg::RA_IDX:    ra_wide = idx_ext;
      ilir_pkg::RA_OTH:    ra_wide = oth_ext;
      ilir_pkg::RA_IDX_P1: ra_wide = idx_p1;
      ilir_pkg::RA_CNT_M1: ra_wide = count - ilir_pkg::CW'(1);
      ilir_pkg::RA_PTR_M2: ra_wide = ptr - ilir_pkg::CW'(2);
      ilir_pkg::RA_PTR_P2: ra_wide = ptr + ilir_pkg::CW'(2);
      default:             ra_wide = idx_ext;
    endcase
    case (cmd.wa_sel)
      ilir_pkg::WA_CNT: wa_wide = count;
      ilir_pkg::WA_PTR: wa_wide = ptr;
      ilir_pkg::WA_IDX: wa_wide = idx_ext;
      ilir_pkg::WA_OTH: wa_wide = oth_ext;
      default:          wa_wide = ptr;
    endcase
    case (cmd.wd_sel)
      ilir_pkg::WD_VALUE: wr_data = value;
      ilir_pkg::WD_RDATA: wr_data = rdata;
      ilir_pkg::WD_HOLD:  wr_data = hold;
      default:            wr_data = value;
    endcase
  end

  assign rd_addr = ra_wide[ilir_pkg::AW-1:0];
  assign wr_addr = wa_wide[ilir_pkg::AW-1:0];

  // Memory port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Swap holding word
  always_ff @(posedge clk) begin
    if (cmd.hold_ld) begin
      hold <= rdata;
    end
  end

  // Shift pointer and entry count
  always_comb begin
    case (cmd.ptr_op)
      ilir_pkg::PTR_HOLD: ptr_next = ptr;
      ilir_pkg::PTR_CNT:  ptr_next = count;
      ilir_pkg::PTR_IDX:  ptr_next = idx_ext;
      ilir_pkg::PTR_DEC:  ptr_next = ptr - ilir_pkg::CW'(1);
      ilir_pkg::PTR_INC:  ptr_next = ptr + ilir_pkg::CW'(1);
      default:            ptr_next = ptr;
    endcase
    case (cmd.cnt_op)
      ilir_pkg::CNT_HOLD: count_next = count;
      ilir_pkg::CNT_INC:  count_next = count + ilir_pkg::CW'(1);
      ilir_pkg::CNT_DEC:  count_next = count - ilir_pkg::CW'(1);
      default:            count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (cmd.st_ld) begin
      res_status <= cmd.st_code;
      res_read   <= '0;
    end else if (cmd.rv_ld) begin
      res_read <= rdata;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      rsp_read_value  <= res_read;
      rsp_status      <= res_status;
      rsp_entry_count <= count;
    end
  end

  // Status to controller
  always_comb begin
    stat.kind          = kind;
    stat.full          = (count == ilir_pkg::CW'(ilir_pkg::CAPACITY));
    stat.idx_le_cnt    = (idx_ext <= count);
    stat.idx_eq_cnt    = (idx_ext == count);
    stat.idx_lt_cnt    = (idx_ext < count);
    stat.oth_lt_cnt    = (oth_ext < count);
    stat.idx_p1_eq_cnt = (idx_p1 == count);
    stat.ptr_gt_idx_p1 = (ptr > idx_p1);
    stat.ptr_p2_lt_cnt = ((ptr + ilir_pkg::CW'(2)) < count);
    stat.out_free      = !rsp_valid || rsp_ready;
  end

  // Checks
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= ilir_pkg::CW'(ilir_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_port_no_clash: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en && cmd.wr_en |-> rd_addr != wr_addr)
    else $error("read and write hit the same entry");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (count != $past(count)) |->
      (count == $past(count) + ilir_pkg::CW'(1)) ||
      (count + ilir_pkg::CW'(1) == $past(count)))
    else $error("entry count moved by more than one");

endmodule

// ===== design/ilir_ctrl.sv =====
module ilir_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  ilir_pkg::ilir_stat_t stat,
  output ilir_pkg::ilir_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DEC      = 4'd1;
  localparam logic [3:0] S_INS_LOOP = 4'd2;
  localparam logic [3:0] S_INS_LAST = 4'd3;
  localparam logic [3:0] S_REM_LOOP = 4'd4;
  localparam logic [3:0] S_SW_B     = 4'd5;
  localparam logic [3:0] S_SW_C     = 4'd6;
  localparam logic [3:0] S_SW_D     = 4'd7;
  localparam logic [3:0] S_RD_B     = 4'd8;
  localparam logic [3:0] S_FIN      = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.rd_sel  = ilir_pkg::RA_IDX;
    cmd.wa_sel  = ilir_pkg::WA_PTR;
    cmd.wd_sel  = ilir_pkg::WD_VALUE;
    cmd.ptr_op  = ilir_pkg::PTR_HOLD;
    cmd.cnt_op  = ilir_pkg::CNT_HOLD;
    cmd.st_code = ilir_pkg::ST_DONE;
    case (state)
      S_IDLE: begin
        cmd.capture = req_valid;
        if (req_valid) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cmd.st_ld  = 1'b1;
        state_next = S_FIN;
        case (stat.kind)
          ilir_pkg::KIND_APPEND: begin
            if (stat.full) begin
              cmd.st_code = ilir_pkg::ST_FULL;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wa_sel = ilir_pkg::WA_CNT;
              cmd.cnt_op = ilir_pkg::CNT_INC;
            end
          end
          ilir_pkg::KIND_INSERT: begin
            if (stat.full) begin
              cmd.st_code = ilir_pkg::ST_FULL;
            end else if (!stat.idx_le_cnt) begin
              cmd.st_code = ilir_pkg::ST_RANGE;
            end else if (stat.idx_eq_cnt) begin
              cmd.wr_en  = 1'b1;
              cmd.wa_sel = ilir_pkg::WA_IDX;
              cmd.cnt_op = ilir_pkg::CNT_INC;
            end else begin
              // prime the upward shift with the last entry
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ilir_pkg::RA_CNT_M1;
              cmd.ptr_op = ilir_pkg::PTR_CNT;
              state_next = S_INS_LOOP;
            end
          end
          ilir_pkg::KIND_REMOVE: begin
            if (!stat.idx_lt_cnt) begin
              cmd.st_code = ilir_pkg::ST_RANGE;
            end else if (stat.idx_p1_eq_cnt) begin
              cmd.cnt_op = ilir_pkg::CNT_DEC;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ilir_pkg::RA_IDX_P1;
              cmd.ptr_op = ilir_pkg::PTR_IDX;
              state_next = S_REM_LOOP;
            end
          end
          ilir_pkg::KIND_SWAP: begin
            if (!(stat.idx_lt_cnt && stat.oth_lt_cnt)) begin
              cmd.st_code = ilir_pkg::ST_RANGE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ilir_pkg::RA_IDX;
              state_next = S_SW_B;
            end
          end
          ilir_pkg::KIND_READ: begin
            if (!stat.idx_lt_cnt) begin
              cmd.st_code = ilir_pkg::ST_RANGE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ilir_pkg::RA_IDX;
              state_next = S_RD_B;
            end
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_INS_LOOP: begin
        // move one entry up, fetch the next one below
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = ilir_pkg::WA_PTR;
        cmd.wd_sel = ilir_pkg::WD_RDATA;
        cmd.ptr_op = ilir_pkg::PTR_DEC;
        if (stat.ptr_gt_idx_p1) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ilir_pkg::RA_PTR_M2;
        end else begin
          state_next = S_INS_LAST;
        end
      end
      S_INS_LAST: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = ilir_pkg::WA_IDX;
        cmd.wd_sel = ilir_pkg::WD_VALUE;
        cmd.cnt_op = ilir_pkg::CNT_INC;
        state_next = S_FIN;
      end
      S_REM_LOOP: begin
        // move one entry down, fetch the next one above
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = ilir_pkg::WA_PTR;
        cmd.wd_sel = ilir_pkg::WD_RDATA;
        cmd.ptr_op = ilir_pkg::PTR_INC;
        if (stat.ptr_p2_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ilir_pkg::RA_PTR_P2;
        end else begin
          cmd.cnt_op = ilir_pkg::CNT_DEC;
          state_next = S_FIN;
        end
      end
      S_SW_B: begin
        cmd.hold_ld = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = ilir_pkg::RA_OTH;
        state_next  = S_SW_C;
      end
      S_SW_C: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = ilir_pkg::WA_IDX;
        cmd.wd_sel = ilir_pkg::WD_RDATA;
        state_next = S_SW_D;
      end
      S_SW_D: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = ilir_pkg::WA_OTH;
        cmd.wd_sel = ilir_pkg::WD_HOLD;
        state_next = S_FIN;
      end
      S_RD_B: begin
        cmd.rv_ld  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Checks
  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == S_DEC)
    else $error("accepted word not decoded");

  a_fin_waits: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && !stat.out_free |=> state == S_FIN)
    else $error("result dropped while output busy");

endmodule

// ===== design/indexed_list_insert_remove.sv =====
// Sequence: each accepted request is decoded, then ends by loading its result word;
// rejected requests and appends go straight there, reads and swaps pass through
// memory steps first, and removes and inserts first shift the entries past the index.
// Throughput: one request at a time; the next is taken once the result is
// loaded into the output register. Shifts move one entry per cycle through
// the one-write, one-read entry memory.
// Reset: rst (synchronous) empties the list; entry contents are not cleared.
module indexed_list_insert_remove (
  input  logic       clk,
  input  logic       rst,
  ilir_req_if.sink   req,
  ilir_rsp_if.source rsp
);

  ilir_pkg::ilir_cmd_t  cmd;
  ilir_pkg::ilir_stat_t stat;

  ilir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ilir_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .req_kind        (req.kind),
    .req_index       (req.index),
    .req_other_index (req.other_index),
    .req_value       (req.value),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_read_value  (rsp.read_value),
    .rsp_status      (rsp.status),
    .rsp_entry_count (rsp.entry_count)
  );

endmodule
